### rtl/arl_pkg.sv
// ----------------------------------------------------------------------------
// arl_pkg
// Shared types, codes and checksum helper for the ack/retry link endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

package arl_pkg;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_BODY = 2'd0,   // outgoing body byte
        ACT_RX   = 2'd1,   // byte received from the link
        ACT_TICK = 2'd2,   // one time tick
        ACT_NONE = 2'd3    // no operation
    } t_action;

    // Event codes on the result
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACK    = 2'd1,
        EV_RESEND = 2'd2,
        EV_FAIL   = 2'd3
    } t_event;

    // Endpoint mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_WAIT = 2'd2
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [1:0] CFG_FRAME_END_CHAR = 2'd2;

    localparam logic [7:0]  RST_RETRY_LIMIT    = 8'd3;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd1000;
    localparam logic [7:0]  RST_FRAME_END_CHAR = 8'd0;

    // Acknowledge frame characters
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_K = 8'h4B;

    localparam logic [7:0] CHECK_MOD    = 8'd25;
    localparam logic [7:0] CHECK_OFFSET = 8'd97;

    // Count of ACK frame bytes before the end character, also the full-match count
    localparam logic [2:0] MATCH_FULL = 3'd4;

    // Most results per input item
    localparam int unsigned MAX_RES = 5;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       host_valid;
        logic [7:0] host_byte;
        logic       host_end;
        t_event     event_res;
        logic [7:0] resend_count;
    } t_result;

    // (acc mod 25) + 97; quotient by reciprocal 41/1024, exact for 8-bit acc
    function automatic logic [7:0] finish_check(input logic [7:0] acc);
        logic [13:0] prod;
        logic [3:0]  quo;
        logic [7:0]  rem;
        prod = 14'(acc) * 14'd41;
        quo  = prod[13:10];
        rem  = acc - 8'({4'd0, quo} * CHECK_MOD);
        return rem + CHECK_OFFSET;
    endfunction

endpackage

`default_nettype wire

### rtl/arl_in_if.sv
// ----------------------------------------------------------------------------
// arl_in_if
// Request channel into the endpoint: action, data byte and last-of-body flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface arl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       body_last;

    modport source (output valid, action, data_byte, body_last, input ready);
    modport sink   (input valid, action, data_byte, body_last, output ready);
endinterface

`default_nettype wire

### rtl/arl_out_if.sv
// ----------------------------------------------------------------------------
// arl_out_if
// Result channel out of the endpoint: link byte, host byte and events.
// ----------------------------------------------------------------------------
`default_nettype none

interface arl_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       host_valid;
    logic [7:0] host_byte;
    logic       host_end;
    logic [1:0] event_res;
    logic [7:0] resend_count;
    logic       final_res;

    modport source (output valid, tx_valid, tx_byte, host_valid, host_byte, host_end,
                    event_res, resend_count, final_res, input ready);
    modport sink   (input valid, tx_valid, tx_byte, host_valid, host_byte, host_end,
                    event_res, resend_count, final_res, output ready);
endinterface

`default_nettype wire

### rtl/ack_retry_link_endpoint_unit.sv
// ----------------------------------------------------------------------------
// ack_retry_link_endpoint_unit
// Stop-and-wait link endpoint with checksum acknowledgement and retry timer.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Carries
//  --------  ---  -------------------  --------------------------------------
//  i_in      in   valid/ready          action, data_byte, body_last
//  o_out     out  valid/ready          tx/host bytes, host_end, event, final
//  i_cfg_*   in   write enable only    retry_limit, timeout_ticks, end char
//
//  One request is registered, processed combinationally against the endpoint
//  state, and its 0..5 results land in a small result shift register. A request
//  that yields one result sustains one request per cycle while the output is
//  ready; a request with more results holds the next one until they are taken.
//  The next request is processed in the same cycle the last pending result is
//  taken, so output stalls only back up through the input register.
//  Synchronous active-low reset: idle mode, empty stages, registers at default.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_retry_link_endpoint_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    arl_in_if.sink      i_in,
    arl_out_if.source   o_out,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [15:0]  i_cfg_data
);

    // Configuration
    logic [7:0]  r_retry_limit;
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_frame_end_char;

    // Input register
    logic                r_in_valid;
    arl_pkg::t_action    r_in_action;
    logic [7:0]          r_in_data;
    logic                r_in_last;

    // Endpoint state
    arl_pkg::t_mode r_mode, n_mode;
    logic [7:0]  r_tx_acc, n_tx_acc;
    logic [7:0]  r_tx_pos, n_tx_pos;
    logic [7:0]  r_exp_check, n_exp_check;
    logic [7:0]  r_rx_acc, n_rx_acc;
    logic [7:0]  r_rx_pos, n_rx_pos;
    logic [2:0]  r_match_pos, n_match_pos;
    logic        r_match_ok, n_match_ok;
    logic [15:0] r_wait_timer, n_wait_timer;
    logic [7:0]  r_retry_idx, n_retry_idx;

    // Result shift register; entry 0 is on the port
    arl_pkg::t_result r_res [arl_pkg::MAX_RES];
    arl_pkg::t_result n_res [arl_pkg::MAX_RES];
    logic [2:0]       r_cnt, n_cnt;

    logic w_take, w_proc, w_in_take;

    // Decoded conditions used by next-state and datapath
    logic        w_is_end;
    logic        w_ack_hit;
    logic [16:0] w_timer_inc;
    logic        w_expire;
    logic        w_give_up;
    logic [7:0]  w_base_acc, w_base_pos;
    logic [7:0]  w_body_acc;
    logic [7:0]  w_want;

    assign w_take    = o_out.valid && o_out.ready;
    assign w_proc    = r_in_valid && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready));
    assign i_in.ready = !r_in_valid || w_proc;
    assign w_in_take = i_in.valid && i_in.ready;

    assign w_is_end    = (r_in_data == r_frame_end_char);
    assign w_ack_hit   = r_match_ok && (r_match_pos == arl_pkg::MATCH_FULL);
    assign w_timer_inc = {1'b0, r_wait_timer} + 17'd1;
    assign w_expire    = (w_timer_inc >= {1'b0, r_timeout_ticks});
    assign w_give_up   = (({1'b0, r_retry_idx} + 9'd1) >= {1'b0, r_retry_limit});

    // A body byte in idle starts a fresh frame
    assign w_base_acc = (r_mode == arl_pkg::MODE_IDLE) ? 8'd0 : r_tx_acc;
    assign w_base_pos = (r_mode == arl_pkg::MODE_IDLE) ? 8'd0 : r_tx_pos;
    assign w_body_acc = w_base_acc ^ (r_in_data + w_base_pos);

    always_comb begin
        priority if (r_match_pos == 3'd0) w_want = arl_pkg::CHAR_A;
        else if (r_match_pos == 3'd1)     w_want = arl_pkg::CHAR_C;
        else if (r_match_pos == 3'd2)     w_want = arl_pkg::CHAR_K;
        else                              w_want = r_exp_check;
    end

    // Next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_in_action)
            arl_pkg::ACT_BODY: begin
                if (r_mode != arl_pkg::MODE_WAIT) begin
                    n_mode = r_in_last ? arl_pkg::MODE_WAIT : arl_pkg::MODE_SEND;
                end
            end
            arl_pkg::ACT_RX: begin
                if (r_mode == arl_pkg::MODE_WAIT && w_is_end && w_ack_hit) begin
                    n_mode = arl_pkg::MODE_IDLE;
                end
            end
            arl_pkg::ACT_TICK: begin
                if (r_mode == arl_pkg::MODE_WAIT && w_expire) begin
                    n_mode = w_give_up ? arl_pkg::MODE_IDLE : arl_pkg::MODE_SEND;
                end
            end
            arl_pkg::ACT_NONE: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Datapath and results
    always_comb begin
        n_tx_acc     = r_tx_acc;
        n_tx_pos     = r_tx_pos;
        n_exp_check  = r_exp_check;
        n_rx_acc     = r_rx_acc;
        n_rx_pos     = r_rx_pos;
        n_match_pos  = r_match_pos;
        n_match_ok   = r_match_ok;
        n_wait_timer = r_wait_timer;
        n_retry_idx  = r_retry_idx;
        n_cnt        = 3'd0;
        for (int k = 0; k < arl_pkg::MAX_RES; k++) begin
            n_res[k] = '0;
        end

        unique case (r_in_action)
            arl_pkg::ACT_BODY: begin
                if (r_mode != arl_pkg::MODE_WAIT) begin
                    if (r_mode == arl_pkg::MODE_IDLE) begin
                        n_rx_acc    = 8'd0;
                        n_rx_pos    = 8'd0;
                        n_retry_idx = 8'd0;
                    end
                    n_tx_acc = w_body_acc;
                    n_tx_pos = w_base_pos + 8'd1;
                    n_res[0].tx_valid = 1'b1;
                    n_res[0].tx_byte  = r_in_data;
                    n_cnt = 3'd1;
                    if (r_in_last) begin
                        n_exp_check = arl_pkg::finish_check(w_body_acc);
                        n_res[1].tx_valid = 1'b1;
                        n_res[1].tx_byte  = r_frame_end_char;
                        n_cnt        = 3'd2;
                        n_wait_timer = 16'd0;
                        n_match_pos  = 3'd0;
                        n_match_ok   = 1'b1;
                    end
                end
            end
            arl_pkg::ACT_RX: begin
                if (r_mode == arl_pkg::MODE_IDLE) begin
                    if (w_is_end) begin
                        // frame end: answer with A C K check end
                        n_res[0].tx_valid = 1'b1;
                        n_res[0].tx_byte  = arl_pkg::CHAR_A;
                        n_res[0].host_end = 1'b1;
                        n_res[1].tx_valid = 1'b1;
                        n_res[1].tx_byte  = arl_pkg::CHAR_C;
                        n_res[2].tx_valid = 1'b1;
                        n_res[2].tx_byte  = arl_pkg::CHAR_K;
                        n_res[3].tx_valid = 1'b1;
                        n_res[3].tx_byte  = arl_pkg::finish_check(r_rx_acc);
                        n_res[4].tx_valid = 1'b1;
                        n_res[4].tx_byte  = r_frame_end_char;
                        n_cnt    = 3'd5;
                        n_rx_acc = 8'd0;
                        n_rx_pos = 8'd0;
                    end else begin
                        n_rx_acc = r_rx_acc ^ (r_in_data + r_rx_pos);
                        n_rx_pos = r_rx_pos + 8'd1;
                        n_res[0].host_valid = 1'b1;
                        n_res[0].host_byte  = r_in_data;
                        n_cnt = 3'd1;
                    end
                end else if (r_mode == arl_pkg::MODE_WAIT) begin
                    if (w_is_end) begin
                        if (w_ack_hit) begin
                            n_res[0].event_res    = arl_pkg::EV_ACK;
                            n_res[0].resend_count = r_retry_idx;
                            n_cnt = 3'd1;
                        end
                        n_match_pos = 3'd0;
                        n_match_ok  = 1'b1;
                    end else begin
                        if (r_match_pos >= arl_pkg::MATCH_FULL || r_in_data != w_want) begin
                            n_match_ok = 1'b0;
                        end
                        if (r_match_pos < arl_pkg::MATCH_FULL) begin
                            n_match_pos = r_match_pos + 3'd1;
                        end
                    end
                end
            end
            arl_pkg::ACT_TICK: begin
                if (r_mode == arl_pkg::MODE_WAIT) begin
                    if (w_expire) begin
                        n_cnt = 3'd1;
                        if (w_give_up) begin
                            n_res[0].event_res = arl_pkg::EV_FAIL;
                        end else begin
                            n_res[0].event_res = arl_pkg::EV_RESEND;
                            n_retry_idx = r_retry_idx + 8'd1;
                            n_tx_acc    = 8'd0;
                            n_tx_pos    = 8'd0;
                        end
                        n_wait_timer = 16'd0;
                        n_match_pos  = 3'd0;
                        n_match_ok   = 1'b1;
                    end else begin
                        n_wait_timer = w_timer_inc[15:0];
                    end
                end
            end
            arl_pkg::ACT_NONE: begin
                n_cnt = 3'd0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit    <= arl_pkg::RST_RETRY_LIMIT;
            r_timeout_ticks  <= arl_pkg::RST_TIMEOUT_TICKS;
            r_frame_end_char <= arl_pkg::RST_FRAME_END_CHAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arl_pkg::CFG_RETRY_LIMIT:    r_retry_limit    <= i_cfg_data[7:0];
                arl_pkg::CFG_TIMEOUT_TICKS:  r_timeout_ticks  <= i_cfg_data;
                arl_pkg::CFG_FRAME_END_CHAR: r_frame_end_char <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_action <= arl_pkg::ACT_NONE;
            r_in_data   <= 8'd0;
            r_in_last   <= 1'b0;
        end else if (w_in_take) begin
            r_in_action <= arl_pkg::t_action'(i_in.action);
            r_in_data   <= i_in.data_byte;
            r_in_last   <= i_in.body_last;
        end
    end

    // Endpoint state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= arl_pkg::MODE_IDLE;
            r_tx_acc     <= 8'd0;
            r_tx_pos     <= 8'd0;
            r_exp_check  <= 8'd0;
            r_rx_acc     <= 8'd0;
            r_rx_pos     <= 8'd0;
            r_match_pos  <= 3'd0;
            r_match_ok   <= 1'b1;
            r_wait_timer <= 16'd0;
            r_retry_idx  <= 8'd0;
        end else if (w_proc) begin
            r_mode       <= n_mode;
            r_tx_acc     <= n_tx_acc;
            r_tx_pos     <= n_tx_pos;
            r_exp_check  <= n_exp_check;
            r_rx_acc     <= n_rx_acc;
            r_rx_pos     <= n_rx_pos;
            r_match_pos  <= n_match_pos;
            r_match_ok   <= n_match_ok;
            r_wait_timer <= n_wait_timer;
            r_retry_idx  <= n_retry_idx;
        end
    end

    // Result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_proc) begin
            r_cnt <= n_cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // Result entries: load a new bundle or shift one toward the port
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            for (int k = 0; k < arl_pkg::MAX_RES; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (w_take) begin
            for (int k = 0; k < arl_pkg::MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    assign o_out.valid        = (r_cnt != 3'd0);
    assign o_out.tx_valid     = r_res[0].tx_valid;
    assign o_out.tx_byte      = r_res[0].tx_byte;
    assign o_out.host_valid   = r_res[0].host_valid;
    assign o_out.host_byte    = r_res[0].host_byte;
    assign o_out.host_end     = r_res[0].host_end;
    assign o_out.event_res    = r_res[0].event_res;
    assign o_out.resend_count = r_res[0].resend_count;
    assign o_out.final_res    = (r_cnt == 3'd1);

endmodule

`default_nettype wire

### rtl/arl_checker.sv
// ----------------------------------------------------------------------------
// arl_checker
// Port-level checks on the link endpoint, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module arl_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_tx_valid,
    input wire [7:0] i_tx_byte,
    input wire       i_host_valid,
    input wire [7:0] i_host_byte,
    input wire       i_host_end,
    input wire [1:0] i_event_res,
    input wire [7:0] i_resend_count,
    input wire       i_final_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_byte)
            && $stable(i_host_byte) && $stable(i_event_res) && $stable(i_final_res))
        else $error("result changed while stalled");

    // one kind of payload per result
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0({i_tx_valid, i_host_valid,
                                  i_event_res != arl_pkg::EV_NONE}))
        else $error("result mixes link, host and event payload");

    // unused fields read zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_tx_valid || i_tx_byte == 8'd0)
            && (i_host_valid || i_host_byte == 8'd0)
            && (i_event_res == arl_pkg::EV_ACK || i_resend_count == 8'd0))
        else $error("unused result field not zero");

    // host_end opens an ACK answer: an A byte that is not the final result
    a_end_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_host_end |-> i_tx_valid && i_tx_byte == arl_pkg::CHAR_A
            && !i_final_res)
        else $error("frame end not answered with ACK");

endmodule

bind ack_retry_link_endpoint_unit arl_checker u_arl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_tx_valid     (o_out.tx_valid),
    .i_tx_byte      (o_out.tx_byte),
    .i_host_valid   (o_out.host_valid),
    .i_host_byte    (o_out.host_byte),
    .i_host_end     (o_out.host_end),
    .i_event_res    (o_out.event_res),
    .i_resend_count (o_out.resend_count),
    .i_final_res    (o_out.final_res)
);

`default_nettype wire
